FILE: sv/fpc_pkg.sv
package fpc_pkg;

  typedef enum logic [1:0] {
    REQ_S2H = 2'd0,
    REQ_H2S = 2'd1,
    REQ_S2B = 2'd2,
    REQ_B2S = 2'd3
  } req_t;

  // Operand class. For half sources, CLS_NAN stands for the all-ones
  // exponent, which covers both infinity and NaN.
  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_SUB,
    CLS_NORM,
    CLS_INF,
    CLS_NAN
  } cls_t;

  localparam logic [7:0]  SGL_EXP_ONES  = 8'hFF;
  localparam logic [4:0]  HLF_EXP_ONES  = 5'h1F;
  localparam logic [7:0]  EXP_BIAS_DIFF = 8'd112;
  localparam logic [7:0]  HLF_OVF_EXP   = 8'd143;
  localparam logic [7:0]  HLF_TINY_EXP  = 8'd102;
  localparam logic [7:0]  SUB_SHIFT_REF = 8'd126;
  localparam logic [7:0]  SUB_EXP_REF   = 8'd113;
  localparam logic [14:0] HLF_INF       = 15'h7C00;
  localparam logic [14:0] HLF_QNAN      = 15'h7E00;

  typedef struct packed {
    logic        valid;
    req_t        req;
    cls_t        cls;
    logic [4:0]  hex;
    logic [4:0]  sh;
    logic [3:0]  lz;
    logic [31:0] operand;
  } dec_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] base;
    logic        inc;
  } rnd_t;

endpackage

FILE: sv/fpc_decode.sv
module fpc_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_req_type,
  input  logic [31:0]      in_operand,
  output fpc_pkg::dec_t    dec
);

  fpc_pkg::dec_t dec_r;
  fpc_pkg::dec_t dec_nxt;

  logic [7:0] ex32;
  logic [4:0] ex16;
  logic [9:0] fr16;
  logic [7:0] hex_full;
  logic [7:0] sh_full;
  logic [3:0] lz;

  assign ex32     = in_operand[30:23];
  assign ex16     = in_operand[14:10];
  assign fr16     = in_operand[9:0];
  assign hex_full = ex32 - fpc_pkg::EXP_BIAS_DIFF;
  assign sh_full  = fpc_pkg::SUB_SHIFT_REF - ex32;

  // Shifts needed to bring the top set bit of a half subnormal fraction
  // up to the hidden-bit position.
  always_comb begin
    lz = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (fr16[i]) begin
        lz = 4'(10 - i);
      end
    end
  end

  always_comb begin
    dec_nxt         = '0;
    dec_nxt.valid   = in_valid;
    dec_nxt.req     = fpc_pkg::req_t'(in_req_type);
    dec_nxt.hex     = hex_full[4:0];
    dec_nxt.sh      = sh_full[4:0];
    dec_nxt.lz      = lz;
    dec_nxt.operand = in_operand;
    dec_nxt.cls     = fpc_pkg::CLS_NORM;
    unique case (fpc_pkg::req_t'(in_req_type))
      fpc_pkg::REQ_S2H: begin
        if (ex32 == fpc_pkg::SGL_EXP_ONES) begin
          dec_nxt.cls = (in_operand[22:0] != '0) ? fpc_pkg::CLS_NAN : fpc_pkg::CLS_INF;
        end else if (ex32 >= fpc_pkg::HLF_OVF_EXP) begin
          dec_nxt.cls = fpc_pkg::CLS_INF;
        end else if (ex32 < fpc_pkg::HLF_TINY_EXP) begin
          dec_nxt.cls = fpc_pkg::CLS_ZERO;
        end else if (ex32 <= fpc_pkg::EXP_BIAS_DIFF) begin
          dec_nxt.cls = fpc_pkg::CLS_SUB;
        end else begin
          dec_nxt.cls = fpc_pkg::CLS_NORM;
        end
      end
      fpc_pkg::REQ_H2S: begin
        if (ex16 == '0) begin
          dec_nxt.cls = (fr16 == '0) ? fpc_pkg::CLS_ZERO : fpc_pkg::CLS_SUB;
        end else if (ex16 == fpc_pkg::HLF_EXP_ONES) begin
          dec_nxt.cls = fpc_pkg::CLS_NAN;
        end else begin
          dec_nxt.cls = fpc_pkg::CLS_NORM;
        end
      end
      fpc_pkg::REQ_S2B: dec_nxt.cls = fpc_pkg::CLS_NORM;
      fpc_pkg::REQ_B2S: dec_nxt.cls = fpc_pkg::CLS_NORM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r.valid <= 1'b0;
    end else begin
      dec_r <= dec_nxt;
    end
  end

  assign dec = dec_r;

endmodule

FILE: sv/fpc_round.sv
module fpc_round (
  input  logic          clk,
  input  logic          rst_n,
  input  fpc_pkg::dec_t dec,
  output fpc_pkg::rnd_t rnd
);

  fpc_pkg::rnd_t rnd_r;
  fpc_pkg::rnd_t rnd_nxt;

  logic [31:0] op;
  logic [47:0] shifted;
  logic [10:0] norm16;
  logic [7:0]  sub_exp;
  logic [7:0]  nrm_exp;

  assign op      = dec.operand;
  assign shifted = {1'b1, op[22:0], 24'b0} >> dec.sh;
  assign norm16  = {1'b0, op[9:0]} << dec.lz;
  assign sub_exp = fpc_pkg::SUB_EXP_REF - {4'b0, dec.lz};
  assign nrm_exp = {3'b0, op[14:10]} + fpc_pkg::EXP_BIAS_DIFF;

  always_comb begin
    rnd_nxt       = '0;
    rnd_nxt.valid = dec.valid;
    unique case (dec.req)
      fpc_pkg::REQ_S2H: begin
        case (dec.cls)
          fpc_pkg::CLS_ZERO: rnd_nxt.base = {16'b0, op[31], 15'b0};
          fpc_pkg::CLS_INF:  rnd_nxt.base = {16'b0, op[31], fpc_pkg::HLF_INF};
          fpc_pkg::CLS_NAN:  rnd_nxt.base = {16'b0, op[31], fpc_pkg::HLF_QNAN};
          fpc_pkg::CLS_SUB: begin
            // Shift is at least 14, so the kept mantissa fits in ten bits.
            rnd_nxt.base = {16'b0, op[31], 5'b0, shifted[33:24]};
            rnd_nxt.inc  = shifted[23] & ((|shifted[22:0]) | shifted[24]);
          end
          default: begin
            rnd_nxt.base = {16'b0, op[31], dec.hex, op[22:13]};
            rnd_nxt.inc  = op[12] & ((|op[11:0]) | op[13]);
          end
        endcase
      end
      fpc_pkg::REQ_H2S: begin
        case (dec.cls)
          fpc_pkg::CLS_ZERO: rnd_nxt.base = {op[15], 31'b0};
          fpc_pkg::CLS_SUB:  rnd_nxt.base = {op[15], sub_exp, norm16[9:0], 13'b0};
          fpc_pkg::CLS_NAN:  rnd_nxt.base = {op[15], fpc_pkg::SGL_EXP_ONES, op[9:0], 13'b0};
          default:           rnd_nxt.base = {op[15], nrm_exp, op[9:0], 13'b0};
        endcase
      end
      fpc_pkg::REQ_S2B: begin
        rnd_nxt.base = {16'b0, op[31:16]};
        rnd_nxt.inc  = op[15] & ((|op[14:0]) | op[16]);
      end
      fpc_pkg::REQ_B2S: rnd_nxt.base = {op[15:0], 16'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r.valid <= 1'b0;
    end else begin
      rnd_r <= rnd_nxt;
    end
  end

  assign rnd = rnd_r;

endmodule

FILE: sv/fpc_pack.sv
module fpc_pack (
  input  logic          clk,
  input  logic          rst_n,
  input  fpc_pkg::rnd_t rnd,
  output logic          out_valid,
  output logic [31:0]   out_result
);

  logic        out_valid_r;
  logic [31:0] out_result_r;
  logic [31:0] out_result_nxt;

  // The increment stays in the low half: a half-precision carry runs from the
  // mantissa into the exponent, and bfloat16 wraps within 16 bits.
  assign out_result_nxt = {rnd.base[31:16], rnd.base[15:0] + {15'b0, rnd.inc}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rnd.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

FILE: sv/float_format_converter.sv
// A request accepted at a clock edge passes the decode, round and pack
// registers (three register stages) before its result is strobed on out_valid.
// Throughput: one request per cycle; busy never rises, since the stages
// always advance and the receiver cannot stall.
// Reset: synchronous active-low rst_n clears the stage valid bits only.
module float_format_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_operand,
  output logic        out_valid,
  output logic [31:0] out_result
);

  fpc_pkg::dec_t dec;
  fpc_pkg::rnd_t rnd;

  assign busy = 1'b0;

  fpc_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (start),
    .in_req_type (in_req_type),
    .in_operand  (in_operand),
    .dec         (dec)
  );

  fpc_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .dec   (dec),
    .rnd   (rnd)
  );

  fpc_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .rnd        (rnd),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

FILE: sv/fpc_checker.sv
module fpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_req_type,
  input logic [31:0] in_operand,
  input logic        out_valid,
  input logic [31:0] out_result
);

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted request produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##3 !out_valid)
    else $error("result strobed without a request");

  a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == fpc_pkg::REQ_S2H || in_req_type == fpc_pkg::REQ_S2B))
    |-> ##3 (out_result[31:16] == 16'b0))
    else $error("16-bit result has nonzero upper half");

  a_bf16_widen: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == fpc_pkg::REQ_B2S)
    |-> ##3 (out_result == {$past(in_operand[15:0], 3), 16'b0}))
    else $error("bfloat16 widening result mismatch");

endmodule

bind float_format_converter fpc_checker u_fpc_checker (.*);
